[hw/rtl/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// bcf_pkg
// shared types and constants of the bezier curve flattener
// ----------------------------------------------------------------------------
package bcf_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int MAX_STEPS_DEF   = 63;
   localparam int STEP_W          = 6;
   localparam int T_W             = 17;
   localparam int DIV_STEPS       = 17;

   localparam logic [STEP_W-1:0] STEP_RESET = 6'd8;
   localparam logic [T_W-1:0]    ONE_Q16    = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_CAPTURE,
      ST_PUSH
   } state_type;

   typedef enum logic [1:0] {
      OUT_POINT,
      OUT_SINGLE,
      OUT_ERROR
   } out_kind_type;

   typedef struct packed {
      logic         store_pt;
      logic [1:0]   held_idx;
      logic         div_init;
      logic         div_step;
      logic         walk_init;
      logic         walk_next;
      logic         load_axis;
      logic         mul;
      logic         acc;
      logic         cap_axis;
      logic [1:0]   axis;
      logic [1:0]   k;
      logic         out_load;
      out_kind_type out_kind;
      logic         out_last;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
   } stat_type;

endpackage

[hw/rtl/bcf_datapath.sv]
// ----------------------------------------------------------------------------
// bcf_datapath
// point store, step divider, t walker, shared lerp unit and output register
// ----------------------------------------------------------------------------
module bcf_datapath #(
   parameter int COORD_WIDTH = bcf_pkg::COORD_WIDTH_DEF,
   parameter int MAX_STEPS   = bcf_pkg::MAX_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bcf_pkg::cmd_type             cmd,
   output bcf_pkg::stat_type            stat,
   input  logic                         csr_we,
   input  logic [bcf_pkg::STEP_W-1:0]   csr_wdata,
   input  logic [COORD_WIDTH-1:0]       in_x,
   input  logic [COORD_WIDTH-1:0]       in_y,
   input  logic [COORD_WIDTH-1:0]       in_z,
   output logic [COORD_WIDTH-1:0]       out_x,
   output logic [COORD_WIDTH-1:0]       out_y,
   output logic [COORD_WIDTH-1:0]       out_z,
   output logic                         out_last,
   output logic                         out_err
);
   import bcf_pkg::*;

   localparam int PW = COORD_WIDTH + T_W + 2;

   logic [STEP_W-1:0]      step_ff;
   logic [STEP_W-1:0]      step_eff;
   logic [COORD_WIDTH-1:0] sx_ff [4];
   logic [COORD_WIDTH-1:0] sy_ff [4];
   logic [COORD_WIDTH-1:0] sz_ff [4];
   logic [COORD_WIDTH-1:0] w_ff  [4];
   logic [COORD_WIDTH-1:0] res_ff [3];
   logic signed [PW-1:0]   prod_ff;
   logic signed [PW-1:0]   prod_in;
   logic signed [COORD_WIDTH:0] diff;
   logic [1:0]             kp;

   logic [T_W-1:0]         dvd_ff;
   logic [STEP_W-1:0]      rem_ff;
   logic [T_W-1:0]         base_ff;
   logic [STEP_W:0]        trial;
   logic                   trial_ge;

   logic [STEP_W-1:0]      i_ff;
   logic [T_W-1:0]         t_ff;
   logic [STEP_W-1:0]      r_ff;
   logic [STEP_W:0]        r_sum;
   logic                   r_ge;

   logic [COORD_WIDTH-1:0] ox_ff, oy_ff, oz_ff;
   logic                   olast_ff, oerr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (csr_we) begin
         step_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (step_ff == '0) begin
         step_eff = STEP_W'(1);
      end else if (step_ff > STEP_W'(MAX_STEPS)) begin
         step_eff = STEP_W'(MAX_STEPS);
      end else begin
         step_eff = step_ff;
      end
   end

   // restoring divider for 65536 / steps, msb first
   assign trial    = {rem_ff, dvd_ff[T_W-1]};
   assign trial_ge = trial >= {1'b0, step_eff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff  <= ONE_Q16;
         rem_ff  <= '0;
         base_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[T_W-2:0], 1'b0};
         rem_ff  <= trial_ge ? STEP_W'(trial - {1'b0, step_eff}) : STEP_W'(trial);
         base_ff <= {base_ff[T_W-2:0], trial_ge};
      end
   end

   // t walker: t = floor(i*65536/steps) by quotient plus remainder
   assign r_sum = {1'b0, r_ff} + {1'b0, rem_ff};
   assign r_ge  = r_sum >= {1'b0, step_eff};

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         i_ff <= '0;
         t_ff <= '0;
         r_ff <= '0;
      end else if (cmd.walk_next) begin
         i_ff <= i_ff + STEP_W'(1);
         t_ff <= t_ff + base_ff + T_W'(r_ge);
         r_ff <= r_ge ? STEP_W'(r_sum - {1'b0, step_eff}) : STEP_W'(r_sum);
      end
   end

   assign stat.walk_last = (i_ff == step_eff);

   always_ff @(posedge clock) begin
      if (cmd.store_pt) begin
         sx_ff[cmd.held_idx] <= in_x;
         sy_ff[cmd.held_idx] <= in_y;
         sz_ff[cmd.held_idx] <= in_z;
      end
   end

   // lerp: a + floor((b - a) * t / 65536)
   assign kp      = cmd.k + 2'd1;
   assign diff    = $signed({w_ff[kp][COORD_WIDTH-1], w_ff[kp]})
                  - $signed({w_ff[cmd.k][COORD_WIDTH-1], w_ff[cmd.k]});
   assign prod_in = PW'(diff * $signed({1'b0, t_ff}));

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_axis) begin
         for (int j = 0; j < 4; j++) begin
            unique case (cmd.axis)
               2'd0:    w_ff[j] <= sx_ff[j];
               2'd1:    w_ff[j] <= sy_ff[j];
               default: w_ff[j] <= sz_ff[j];
            endcase
         end
      end else if (cmd.acc) begin
         w_ff[cmd.k] <= w_ff[cmd.k] + prod_ff[COORD_WIDTH+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_axis) begin
         unique case (cmd.axis)
            2'd0:    res_ff[0] <= w_ff[0];
            2'd1:    res_ff[1] <= w_ff[0];
            default: res_ff[2] <= w_ff[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         olast_ff <= cmd.out_last;
         unique case (cmd.out_kind)
            OUT_POINT: begin
               ox_ff   <= res_ff[0];
               oy_ff   <= res_ff[1];
               oz_ff   <= res_ff[2];
               oerr_ff <= 1'b0;
            end
            OUT_SINGLE: begin
               ox_ff   <= sx_ff[0];
               oy_ff   <= sy_ff[0];
               oz_ff   <= sz_ff[0];
               oerr_ff <= 1'b0;
            end
            default: begin
               ox_ff   <= '0;
               oy_ff   <= '0;
               oz_ff   <= '0;
               oerr_ff <= 1'b1;
            end
         endcase
      end
   end

   assign out_x    = ox_ff;
   assign out_y    = oy_ff;
   assign out_z    = oz_ff;
   assign out_last = olast_ff;
   assign out_err  = oerr_ff;

endmodule

[hw/rtl/bcf_ctrl.sv]
// ----------------------------------------------------------------------------
// bcf_ctrl
// sequencer: point intake, divide, lerp schedule and output handshake
// ----------------------------------------------------------------------------
module bcf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output bcf_pkg::cmd_type   cmd,
   input  bcf_pkg::stat_type  stat
);
   import bcf_pkg::*;

   state_type    state_ff, state_in;
   out_kind_type kind_ff, kind_in;
   logic [2:0]   held_ff, held_in;
   logic [2:0]   n_ff, n_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [1:0]   axis_ff, axis_in;
   logic [1:0]   lvl_ff, lvl_in;
   logic [1:0]   k_ff, k_in;
   logic         valid_ff, valid_in;
   logic         out_free;
   logic [2:0]   held_sat;

   assign out_free = !valid_ff || rsp_tready;
   assign held_sat = (held_ff < 3'd5) ? held_ff + 3'd1 : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         valid_ff <= 1'b0;
         kind_ff  <= OUT_POINT;
         n_ff     <= '0;
         cnt_ff   <= '0;
         axis_ff  <= '0;
         lvl_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         valid_ff <= valid_in;
         kind_ff  <= kind_in;
         n_ff     <= n_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
         lvl_ff   <= lvl_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      held_in    = held_ff;
      kind_in    = kind_ff;
      n_in       = n_ff;
      cnt_in     = cnt_ff;
      axis_in    = axis_ff;
      lvl_in     = lvl_ff;
      k_in       = k_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.k      = k_ff;
      cmd.held_idx = held_ff[1:0];
      cmd.out_kind = kind_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.store_pt = (held_ff < 3'd4);
               held_in      = held_sat;
               if (req_tlast) begin
                  held_in = '0;
                  n_in    = held_sat;
                  if (held_sat > 3'd4) begin
                     kind_in  = OUT_ERROR;
                     state_in = ST_PUSH;
                  end else if (held_sat == 3'd1) begin
                     kind_in  = OUT_SINGLE;
                     state_in = ST_PUSH;
                  end else begin
                     kind_in      = OUT_POINT;
                     cmd.div_init = 1'b1;
                     cnt_in       = '0;
                     state_in     = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               axis_in  = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_axis = 1'b1;
            if (cnt_ff == 5'(DIV_STEPS)) begin
               cmd.walk_init = 1'b1;
               cnt_in        = '0;
            end
            lvl_in   = 2'(n_ff - 3'd1);
            k_in     = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (k_ff + 2'd1 < lvl_ff) begin
               k_in     = k_ff + 2'd1;
               state_in = ST_MUL;
            end else if (lvl_ff > 2'd1) begin
               lvl_in   = lvl_ff - 2'd1;
               k_in     = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_CAPTURE;
            end
         end
         ST_CAPTURE: begin
            cmd.cap_axis = 1'b1;
            if (axis_ff < 2'd2) begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.out_last = (kind_ff == OUT_POINT) ? stat.walk_last : 1'b1;
            if (out_free) begin
               cmd.out_load = 1'b1;
               if (kind_ff == OUT_POINT && !stat.walk_last) begin
                  cmd.walk_next = 1'b1;
                  axis_in       = '0;
                  state_in      = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign valid_in   = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   assign rsp_tvalid = valid_ff;

`ifndef SYNTHESIS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("output word overwritten before taken");
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      held_ff <= 3'd5)
      else $error("point count out of range");
   a_lerp_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (k_ff < lvl_ff && {1'b0, lvl_ff} < n_ff))
      else $error("lerp index beyond curve order");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.out_last) |=> (state_ff == ST_IDLE))
      else $error("segment end did not return to idle");
`endif

endmodule

[hw/rtl/bezier_curve_flattener.sv]
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// de casteljau flattening of point, line, quadratic and cubic segments
// ----------------------------------------------------------------------------
// usage:
//   req_* carries control points, one word each, req_tlast on the last point
//   of a segment. one point passes through, two to four points give a line or
//   curve flattened into steps+1 points on rsp_*, rsp_tlast on the final one.
//   five or more points give a single zero word with the error flag in tuser.
//   csr_we/csr_wdata set the step count (reset 8, 0 acts as 1).
// sequence:
//   a non-final point is taken while idle. a closing point starts the step
//   division, then each emitted point takes, per axis, a load, a multiply
//   and an accumulate for each of 1, 3 or 6 lerps (line, quadratic or cubic)
//   and a capture on the shared lerp multiplier, then a push. the next
//   segment is taken after the last word is loaded into the output register.
// reset: step count back to 8, open segment dropped, output empty.
// stall: the output register holds its word; the next point is computed
//   meanwhile and waits until the register frees.
// ----------------------------------------------------------------------------
module bezier_curve_flattener #(
   parameter int COORD_WIDTH = bcf_pkg::COORD_WIDTH_DEF,
   parameter int MAX_STEPS   = bcf_pkg::MAX_STEPS_DEF,
   parameter int DATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   // config
   input  logic                       csr_we,
   input  logic [bcf_pkg::STEP_W-1:0] csr_wdata,     // step_count
   // control points
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [DATA_W-1:0]          req_tdata,     // x_coord, y_coord, z_coord
   input  logic                       req_tlast,     // segment_end
   // emitted points
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,     // out_x, out_y, out_z
   output logic                       rsp_tlast,     // last_of_run
   output logic                       rsp_tuser      // too_many_points
);
   import bcf_pkg::*;

   cmd_type                cmd;
   stat_type               stat;
   logic [COORD_WIDTH-1:0] out_x, out_y, out_z;

   // sequencer
   bcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // arithmetic and storage
   bcf_datapath #(
      .COORD_WIDTH (COORD_WIDTH),
      .MAX_STEPS   (MAX_STEPS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_x      (req_tdata[COORD_WIDTH-1:0]),
      .in_y      (req_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
      .in_z      (req_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .out_x     (out_x),
      .out_y     (out_y),
      .out_z     (out_z),
      .out_last  (rsp_tlast),
      .out_err   (rsp_tuser)
   );

   // pack fields, zero fill to whole bytes
   assign rsp_tdata = DATA_W'({out_z, out_y, out_x});

endmodule
